@@ rtl/core/bbpf_pkg.sv @@
// shared types and constants of the bitmap blit frame store
package bbpf_pkg;

	localparam logic [1:0] KIND_DRAW  = 2'd0;
	localparam logic [1:0] KIND_READ  = 2'd1;
	localparam logic [1:0] KIND_DIRTY = 2'd2;

	localparam int          PAGE_W     = 4;
	localparam logic [2:0]  BIT_MASK   = 3'h7;
	localparam logic [7:0]  BYTE_ONES  = 8'hff;

	typedef struct packed {
		logic [1:0] kind;
		logic [6:0] origin_x;
		logic [5:0] origin_y;
		logic [7:0] img_width;
		logic [6:0] img_height;
		logic [6:0] img_column;
		logic [2:0] img_row_byte;
		logic [7:0] image_byte;
	} req_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic [7:0] dirty_mask;
	} res_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RD0,
		ST_WR0,
		ST_RD1,
		ST_WR1,
		ST_READ,
		ST_READ_OUT
	} state_t;

endpackage

@@ rtl/core/bbpf_ram.sv @@
// generic single-port ram with registered read
module bbpf_ram #(
	parameter int WIDTH  = 8,
	parameter int DEPTH  = 1024,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] addr,
	input  logic [WIDTH-1:0]  wdata,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

@@ rtl/core/bitmap_blit_paged_framebuffer_unit.sv @@
// top level of the paged monochrome frame store with bitmap blit
// After reset the block clears its frame memory, one byte per cycle, all
// ((SCREEN_ROWS+7)/8)*SCREEN_COLUMNS bytes (1024 by default), with busy high.
// A request is taken when start is high and busy low. A draw request holds
// busy through a read state and a write state per frame byte it touches
// (RD0/WR0, plus RD1/WR1 when it straddles two pages; none off screen or
// outside the image), as every touched byte is a read-modify-write through
// the single memory port and the one shared merge unit. A frame read holds
// busy through READ and READ_OUT, its result registered on leaving READ_OUT;
// a dirty-mask take never raises busy and its result comes the next cycle.
// Each result shows on res for one cycle with done high; it cannot be held.
module bitmap_blit_paged_framebuffer_unit #(
	parameter int SCREEN_COLUMNS = 128,
	parameter int SCREEN_ROWS    = 64
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  bbpf_pkg::req_t  req,
	output logic            done,
	output bbpf_pkg::res_t  res
);

	localparam int PAGE_COUNT  = (SCREEN_ROWS + 7) / 8;
	localparam int STORE_BYTES = PAGE_COUNT * SCREEN_COLUMNS;
	localparam int AW          = $clog2(STORE_BYTES);

	bbpf_pkg::state_t state_q, state_d;

	logic [AW-1:0]  clr_q;
	logic [AW-1:0]  addr0_q, addr1_q;
	logic [15:0]    wmask_q, wdata_q;
	logic           rd_ok_q;
	logic [7:0]     dirty_q;
	logic           done_q;
	bbpf_pkg::res_t res_q;

	logic           accept;
	logic           ram_we;
	logic [AW-1:0]  ram_addr;
	logic [7:0]     ram_wdata, ram_rdata;
	logic [7:0]     merge_mask, merge_data;

	// draw decode
	logic [7:0]                  x_sum;
	logic                        col_ok, h_ok, x_ok, draw_ok;
	logic [6:0]                  rem, base, rb8;
	logic [7:0]                  row_ok;
	logic [2:0]                  off;
	logic [bbpf_pkg::PAGE_W-1:0] page0, page1;
	logic [15:0]                 wmask_d, wdata_d;
	logic [AW-1:0]               draw_addr0, draw_addr1;
	logic [7:0]                  dirty_set;
	// read decode
	logic [2:0]                  rd_page;
	logic                        rd_ok;
	logic [AW-1:0]               rd_addr;

	assign accept = start && !busy;

	always_comb begin
		rb8     = {1'b0, req.img_row_byte, 3'b000};
		x_sum   = {1'b0, req.origin_x} + {1'b0, req.img_column};
		col_ok  = {1'b0, req.img_column} < req.img_width;
		h_ok    = req.img_height > rb8;
		x_ok    = {1'b0, x_sum} < 9'(SCREEN_COLUMNS);
		draw_ok = col_ok && h_ok && x_ok;
		rem     = req.img_height - rb8;
		base    = {1'b0, req.origin_y} + rb8;
		for (int i = 0; i < 8; i++) begin
			row_ok[i] = draw_ok && (7'(i) < rem) &&
				(({1'b0, base} + 8'(i)) < 8'(SCREEN_ROWS));
		end
		off     = base[2:0] & bbpf_pkg::BIT_MASK;
		page0   = base[6:3];
		page1   = page0 + 4'd1;
		wmask_d = {8'h00, row_ok} << off;
		wdata_d = {8'h00, req.image_byte} << off;
		draw_addr0 = AW'(int'(page0) * SCREEN_COLUMNS + int'(x_sum));
		draw_addr1 = AW'(int'(page1) * SCREEN_COLUMNS + int'(x_sum));
		for (int p = 0; p < 8; p++) begin
			dirty_set[p] = ((|wmask_d[7:0]) && (page0 == 4'(p))) ||
				((|wmask_d[15:8]) && (page1 == 4'(p)));
		end
		rd_page = req.origin_y[5:3];
		rd_ok   = ({2'b00, req.origin_x} < 9'(SCREEN_COLUMNS)) &&
			({2'b00, rd_page} < 5'(PAGE_COUNT));
		rd_addr = AW'(int'(rd_page) * SCREEN_COLUMNS + int'(req.origin_x));
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			bbpf_pkg::ST_CLEAR: begin
				if (clr_q == AW'(STORE_BYTES - 1)) state_d = bbpf_pkg::ST_IDLE;
			end
			bbpf_pkg::ST_IDLE: begin
				if (accept) begin
					if (req.kind == bbpf_pkg::KIND_DRAW) begin
						if (|wmask_d[7:0]) state_d = bbpf_pkg::ST_RD0;
						else if (|wmask_d[15:8]) state_d = bbpf_pkg::ST_RD1;
					end else if (req.kind == bbpf_pkg::KIND_READ) begin
						state_d = bbpf_pkg::ST_READ;
					end
				end
			end
			bbpf_pkg::ST_RD0:  state_d = bbpf_pkg::ST_WR0;
			bbpf_pkg::ST_WR0: begin
				state_d = (|wmask_q[15:8]) ? bbpf_pkg::ST_RD1 : bbpf_pkg::ST_IDLE;
			end
			bbpf_pkg::ST_RD1:      state_d = bbpf_pkg::ST_WR1;
			bbpf_pkg::ST_WR1:      state_d = bbpf_pkg::ST_IDLE;
			bbpf_pkg::ST_READ:     state_d = bbpf_pkg::ST_READ_OUT;
			bbpf_pkg::ST_READ_OUT: state_d = bbpf_pkg::ST_IDLE;
			default:               state_d = bbpf_pkg::ST_IDLE;
		endcase
	end

	// outputs and memory port
	always_comb begin
		busy       = 1'b1;
		ram_we     = 1'b0;
		ram_addr   = addr0_q;
		merge_mask = wmask_q[7:0];
		merge_data = wdata_q[7:0];
		case (state_q)
			bbpf_pkg::ST_CLEAR: begin
				ram_we     = 1'b1;
				ram_addr   = clr_q;
				merge_mask = bbpf_pkg::BYTE_ONES;
				merge_data = 8'h00;
			end
			bbpf_pkg::ST_IDLE: busy = 1'b0;
			bbpf_pkg::ST_WR0:  ram_we = 1'b1;
			bbpf_pkg::ST_RD1: begin
				ram_addr   = addr1_q;
				merge_mask = wmask_q[15:8];
				merge_data = wdata_q[15:8];
			end
			bbpf_pkg::ST_WR1: begin
				ram_we     = 1'b1;
				ram_addr   = addr1_q;
				merge_mask = wmask_q[15:8];
				merge_data = wdata_q[15:8];
			end
			default: ;
		endcase
		// shared merge unit
		ram_wdata = (ram_rdata & ~merge_mask) | (merge_data & merge_mask);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bbpf_pkg::ST_CLEAR;
			clr_q   <= '0;
			dirty_q <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= 1'b0;
			if (state_q == bbpf_pkg::ST_CLEAR) clr_q <= clr_q + 1'b1;
			if (accept && req.kind == bbpf_pkg::KIND_DRAW) begin
				dirty_q <= dirty_q | dirty_set;
			end
			if (accept && req.kind == bbpf_pkg::KIND_DIRTY) begin
				dirty_q <= '0;
				done_q  <= 1'b1;
			end
			if (state_q == bbpf_pkg::ST_READ_OUT) done_q <= 1'b1;
		end
	end

	// request and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			addr0_q <= (req.kind == bbpf_pkg::KIND_DRAW) ? draw_addr0 : rd_addr;
			addr1_q <= draw_addr1;
			wmask_q <= wmask_d;
			wdata_q <= wdata_d;
			rd_ok_q <= rd_ok;
			if (req.kind == bbpf_pkg::KIND_DIRTY) begin
				res_q.read_data  <= 8'h00;
				res_q.dirty_mask <= dirty_q;
			end
		end
		if (state_q == bbpf_pkg::ST_READ_OUT) begin
			res_q.read_data  <= rd_ok_q ? ram_rdata : 8'h00;
			res_q.dirty_mask <= 8'h00;
		end
	end

	assign done = done_q;
	assign res  = res_q;

	bbpf_ram #(
		.WIDTH (8),
		.DEPTH (STORE_BYTES)
	) u_frame_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	a_done_source: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(state_q == bbpf_pkg::ST_READ_OUT) ||
			$past(accept && req.kind == bbpf_pkg::KIND_DIRTY)))
		else $error("result strobe without a finished read or dirty take");

	a_dirty_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && req.kind == bbpf_pkg::KIND_DIRTY) |=> (dirty_q == 8'h00))
		else $error("dirty mask not cleared after take");

	a_write_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_we && state_q != bbpf_pkg::ST_CLEAR) |->
			($past(state_q == bbpf_pkg::ST_RD0) || $past(state_q == bbpf_pkg::ST_RD1)))
		else $error("frame write without preceding read");

	a_second_byte_masked: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == bbpf_pkg::ST_RD1) |-> (wmask_q[15:8] != 8'h00))
		else $error("second byte access with empty mask");

endmodule

@@ tb/bbpf_frame_checker.sv @@
// watches the frame store ports, predicts read-back and dirty masks, and counts mismatches
`timescale 1ns / 100ps

module bbpf_frame_checker #(
	parameter int SCREEN_COLUMNS = 128,
	parameter int SCREEN_ROWS    = 64
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic            busy,
	input  bbpf_pkg::req_t  req,
	input  logic            done,
	input  bbpf_pkg::res_t  res,
	output int              fails,
	output int              outstanding
);

	localparam int PAGES = (SCREEN_ROWS + 7) / 8;

	logic [7:0]     frame_bytes [PAGES * SCREEN_COLUMNS];
	logic [7:0]     dirty_pages;
	bbpf_pkg::res_t readback_q [$];

	function automatic void blit_byte(bbpf_pkg::req_t r);
		int unsigned x, base, nbits, row, pg, i;
		if (r.img_column >= r.img_width || int'(r.img_height) <= int'(r.img_row_byte) * 8)
			return;
		x = int'(r.origin_x) + int'(r.img_column);
		if (x >= SCREEN_COLUMNS)
			return;
		nbits = int'(r.img_height) - int'(r.img_row_byte) * 8;
		if (nbits > 8)
			nbits = 8;
		base = int'(r.origin_y) + int'(r.img_row_byte) * 8;
		for (i = 0; i < nbits; i++) begin
			row = base + i;
			if (row >= SCREEN_ROWS)
				break;
			pg = row >> 3;
			frame_bytes[pg * SCREEN_COLUMNS + x][row & bbpf_pkg::BIT_MASK] = r.image_byte[i];
			if (pg < 8)
				dirty_pages[pg] = 1'b1;
		end
	endfunction

	function automatic void apply_request(bbpf_pkg::req_t r);
		int unsigned x, pg;
		logic [7:0] v;
		case (r.kind)
			bbpf_pkg::KIND_DRAW: begin
				blit_byte(r);
			end
			bbpf_pkg::KIND_READ: begin
				x = int'(r.origin_x);
				pg = int'(r.origin_y) >> 3;
				v = '0;
				if (x < SCREEN_COLUMNS && pg < PAGES)
					v = frame_bytes[pg * SCREEN_COLUMNS + x];
				readback_q.push_back(bbpf_pkg::res_t'{read_data: v, dirty_mask: 8'h00});
			end
			bbpf_pkg::KIND_DIRTY: begin
				readback_q.push_back(bbpf_pkg::res_t'{read_data: 8'h00,
					dirty_mask: dirty_pages});
				dirty_pages = '0;
			end
			default: begin
			end
		endcase
	endfunction

	function automatic void compare_result(bbpf_pkg::res_t got);
		bbpf_pkg::res_t want;
		if (readback_q.size() == 0) begin
			$display("%0t: unexpected result, expected none, actual read_data %02h dirty_mask %02h",
				$time, got.read_data, got.dirty_mask);
			fails++;
			return;
		end
		want = readback_q.pop_front();
		if (got.read_data !== want.read_data) begin
			$display("%0t: read_data expected %02h, actual %02h",
				$time, want.read_data, got.read_data);
			fails++;
		end
		if (got.dirty_mask !== want.dirty_mask) begin
			$display("%0t: dirty_mask expected %02h, actual %02h",
				$time, want.dirty_mask, got.dirty_mask);
			fails++;
		end
	endfunction

	always @(posedge clk) begin
		if (!arst_n) begin
			dirty_pages = '0;
			foreach (frame_bytes[i]) frame_bytes[i] = '0;
			readback_q.delete();
		end else begin
			if (done === 1'b1)
				compare_result(res);
			if (start === 1'b1 && busy === 1'b0)
				apply_request(req);
		end
		outstanding = readback_q.size();
	end

endmodule

@@ tb/bitmap_blit_paged_framebuffer_unit_test.sv @@
// stimulus and verdict for the bitmap blit frame store, with the checker beside the block
`timescale 1ns / 100ps

module bitmap_blit_paged_framebuffer_unit_test;

	localparam logic [1:0] KIND_NONE   = 2'd3;
	localparam int         TOTAL       = 1525;
	localparam int         QUIET_AFTER = 1300;

	logic           clk;
	logic           arst_n;
	logic           start;
	logic           busy;
	logic           done;
	bbpf_pkg::req_t req;
	bbpf_pkg::res_t res;
	int             fails;
	int             outstanding;
	int             sent;
	bit             quiet;

	bitmap_blit_paged_framebuffer_unit uut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.req    (req),
		.done   (done),
		.res    (res)
	);

	bbpf_frame_checker frame_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.req         (req),
		.done        (done),
		.res         (res),
		.fails       (fails),
		.outstanding (outstanding)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	initial begin
		#1_000_000;
		$display("Verification failed");
		$finish;
	end

	function automatic bbpf_pkg::req_t pack_req(logic [1:0] kind, int unsigned ox,
			int unsigned oy, int unsigned w, int unsigned h, int unsigned col,
			int unsigned rb, int unsigned pix);
		bbpf_pkg::req_t r;
		r.kind = kind;
		r.origin_x = ox[6:0];
		r.origin_y = oy[5:0];
		r.img_width = w[7:0];
		r.img_height = h[6:0];
		r.img_column = col[6:0];
		r.img_row_byte = rb[2:0];
		r.image_byte = pix[7:0];
		return r;
	endfunction

	function automatic bbpf_pkg::req_t read_at(int unsigned x, int unsigned y);
		return pack_req(bbpf_pkg::KIND_READ, x, y, $urandom_range(255), $urandom_range(127),
			$urandom_range(127), $urandom_range(7), $urandom_range(255));
	endfunction

	function automatic bbpf_pkg::req_t take_dirty();
		return pack_req(bbpf_pkg::KIND_DIRTY, $urandom_range(127), $urandom_range(63),
			$urandom_range(255), $urandom_range(127), $urandom_range(127),
			$urandom_range(7), $urandom_range(255));
	endfunction

	function automatic bbpf_pkg::req_t noise_req();
		return pack_req(2'($urandom_range(3)), $urandom_range(127), $urandom_range(63),
			$urandom_range(255), $urandom_range(127), $urandom_range(127),
			$urandom_range(7), $urandom_range(255));
	endfunction

	// called and returns at a falling edge
	task automatic put(bbpf_pkg::req_t r);
		int unsigned gap;
		if (!quiet && $urandom_range(7) == 0) begin
			gap = $urandom_range(1, 17);
			start <= 1'b0;
			req <= bbpf_pkg::req_t'(48'({$urandom, $urandom}));
			repeat (gap) @(negedge clk);
		end
		start <= 1'b1;
		req <= r;
		@(posedge clk);
		while (busy !== 1'b0) @(posedge clk);
		@(negedge clk);
		sent++;
	endtask

	task automatic blit_image();
		int unsigned ox, oy, w, h, c, b, n;
		ox = $urandom_range(127);
		oy = ($urandom_range(3) == 0) ? 8 * $urandom_range(7) : $urandom_range(63);
		if ($urandom_range(19) == 0) begin
			w = 128;
			h = $urandom_range(1, 8);
		end else begin
			w = $urandom_range(1, 10);
			h = ($urandom_range(9) == 0) ? $urandom_range(25, 64) : $urandom_range(1, 24);
		end
		for (c = 0; c < w; c++)
			for (b = 0; b < (h + 7) / 8; b++)
				put(pack_req(bbpf_pkg::KIND_DRAW, ox, oy, w, h, c, b, $urandom_range(255)));
		n = $urandom_range(1, 3);
		repeat (n) begin
			b = oy + $urandom_range(h - 1);
			put(read_at(ox + $urandom_range(w - 1), (b > 63) ? 63 : b));
		end
		if ($urandom_range(3) == 0)
			put(take_dirty());
	endtask

	initial begin
		int unsigned sel, waited;
		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		sent = 0;
		quiet = 1'b1;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// cleared store and empty mask
		put(take_dirty());
		put(read_at(0, 0));
		put(read_at(127, 63));
		// page aligned draw and read back
		put(pack_req(bbpf_pkg::KIND_DRAW, 0, 0, 1, 8, 0, 0, 'ha5));
		put(read_at(0, 0));
		// straddling two pages
		put(pack_req(bbpf_pkg::KIND_DRAW, 10, 5, 8, 16, 3, 0, 'h5a));
		put(read_at(13, 0));
		put(read_at(13, 8));
		// rows past the bottom edge dropped
		put(pack_req(bbpf_pkg::KIND_DRAW, 127, 61, 128, 8, 0, 0, 'hff));
		put(read_at(127, 56));
		// last byte row cut to remaining height
		put(pack_req(bbpf_pkg::KIND_DRAW, 20, 16, 1, 13, 0, 1, 'hff));
		put(read_at(20, 24));
		// clearing bits over set ones
		put(pack_req(bbpf_pkg::KIND_DRAW, 0, 2, 1, 4, 0, 0, 'h00));
		put(read_at(0, 0));
		// byte outside the image, zero sizes and off-screen columns and rows
		put(pack_req(bbpf_pkg::KIND_DRAW, 30, 0, 5, 8, 5, 0, 'hff));
		put(pack_req(bbpf_pkg::KIND_DRAW, 30, 0, 1, 8, 0, 1, 'hff));
		put(pack_req(bbpf_pkg::KIND_DRAW, 30, 8, 0, 0, 0, 0, 'hff));
		put(pack_req(bbpf_pkg::KIND_DRAW, 120, 0, 128, 8, 10, 0, 'hff));
		put(pack_req(bbpf_pkg::KIND_DRAW, 127, 63, 128, 127, 127, 7, 'hff));
		put(pack_req(bbpf_pkg::KIND_DRAW, 40, 63, 128, 127, 0, 7, 'hff));
		put(pack_req(KIND_NONE, 30, 0, 1, 8, 0, 0, 'hff));
		put(read_at(30, 0));
		put(take_dirty());
		put(take_dirty());

		quiet = 1'b0;
		while (sent < TOTAL) begin
			quiet = (sent > QUIET_AFTER);
			sel = $urandom_range(99);
			if (sel < 55)
				blit_image();
			else if (sel < 72)
				put(noise_req());
			else if (sel < 92)
				put(read_at($urandom_range(127), $urandom_range(63)));
			else
				put(take_dirty());
		end
		start <= 1'b0;

		waited = 0;
		while (outstanding != 0 && waited < 2000) begin
			@(negedge clk);
			waited++;
		end
		repeat (8) @(negedge clk);
		if (outstanding != 0)
			$display("%0t: %0d expected results never arrived", $time, outstanding);
		if (fails == 0 && outstanding == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
